@@ sv/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, character codes and helpers for the shell argument tokenizer.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int MAX_RESULTS         = 3;
    localparam int OUT_COUNT_WIDTH     = 16;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_ENDARG = 2'd1,
        KIND_ENDSTR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_t;

    // all results of one item share the same count
    typedef struct packed {
        logic [1:0]                         n;
        kind_t [MAX_RESULTS-1:0]            kind;
        logic [MAX_RESULTS-1:0][7:0]        chr;
        logic [OUT_COUNT_WIDTH-1:0]         count;
    } bundle_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

@@ sv/shell_argument_tokenizer.sv @@
// ----------------------------------------------------------------------------
// shell_argument_tokenizer
// Splits a command string into shell arguments, with quote removal.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | command, char_in
//  result   | pop / empty       | kind, char_out, arg_count, last
//
//  the classifier takes one byte per cycle while full is low and writes
//  its results as one bundle into a four-entry queue; the first result
//  shows once that bundle reaches the head of the queue. the serializer
//  hands out one result per cycle while pop is held; k results take k pops.
//  full rises when four bundles wait and then holds every byte, even one
//  that yields nothing; reset clears the quoting state, count and queue.
// ----------------------------------------------------------------------------
module shell_argument_tokenizer
    import sat_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  char_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  char_out,
    output logic [15:0] arg_count,
    output logic        last
);

    logic    accept;
    logic    bundle_push;
    bundle_t bundle;
    bundle_t head;
    logic    q_empty;
    logic    head_done;

    assign accept = push && !full;

    sat_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .char_in     (char_in),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    sat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_push),
        .wr_data (bundle),
        .rd_en   (head_done),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    sat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .pop        (pop),
        .head_done  (head_done),
        .empty      (empty),
        .kind       (kind),
        .char_out   (char_out),
        .arg_count  (arg_count),
        .last       (last)
    );

endmodule

@@ sv/sat_front.sv @@
// ----------------------------------------------------------------------------
// sat_front
// Classifies each byte against the quoting state and builds one bundle of
// up to three results per transaction.
// ----------------------------------------------------------------------------
module sat_front
    import sat_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        command,
    input  logic [7:0]  char_in,
    output logic        bundle_push,
    output bundle_t     bundle
);

    logic                   in_arg_reg, in_arg_next;
    quote_t                 quote_reg, quote_next;
    logic                   esc_reg, esc_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic                   is_end;
    logic                   do_start;
    logic                   start_eff;
    logic [COUNT_WIDTH-1:0] sat_inc;
    logic [1:0]             n;
    kind_t [MAX_RESULTS-1:0]     kinds;
    logic [MAX_RESULTS-1:0][7:0] chars;

    assign is_end    = command || (char_in == CH_NUL);
    assign sat_inc   = (total_reg == {COUNT_WIDTH{1'b1}}) ? total_reg
                                                          : total_reg + COUNT_WIDTH'(1);
    assign start_eff = do_start && !in_arg_reg;

    always_comb
    begin
        in_arg_next = in_arg_reg;
        quote_next  = quote_reg;
        esc_next    = esc_reg;
        total_next  = total_reg;
        do_start    = 1'b0;
        n           = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
            kinds[i] = KIND_CHAR;
        chars       = '0;

        priority if (is_end)
        begin
            if (esc_reg)
            begin
                do_start = 1'b1;
                n        = 2'd3;
                kinds[0] = KIND_CHAR;
                chars[0] = CH_BSLASH;
                kinds[1] = KIND_ENDARG;
                kinds[2] = KIND_ENDSTR;
            end
            else if (in_arg_reg)
            begin
                n        = 2'd2;
                kinds[0] = KIND_ENDARG;
                kinds[1] = KIND_ENDSTR;
            end
            else
            begin
                n        = 2'd1;
                kinds[0] = KIND_ENDSTR;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            // backslash-newline is a line continuation
            if (char_in != CH_NL)
            begin
                if (quote_reg == QM_DOUBLE)
                begin
                    if (char_in != CH_DQUOTE && char_in != CH_BSLASH)
                    begin
                        n        = 2'd2;
                        chars[0] = CH_BSLASH;
                        chars[1] = char_in;
                    end
                    else
                    begin
                        n        = 2'd1;
                        chars[0] = char_in;
                    end
                end
                else
                begin
                    do_start = 1'b1;
                    n        = 2'd1;
                    chars[0] = char_in;
                end
            end
        end
        else if (quote_reg == QM_SINGLE)
        begin
            if (char_in == CH_SQUOTE)
                quote_next = QM_NONE;
            else
            begin
                n        = 2'd1;
                chars[0] = char_in;
            end
        end
        else if (quote_reg == QM_DOUBLE)
        begin
            priority if (char_in == CH_DQUOTE)
                quote_next = QM_NONE;
            else if (char_in == CH_BSLASH)
                esc_next = 1'b1;
            else
            begin
                n        = 2'd1;
                chars[0] = char_in;
            end
        end
        else
        begin
            priority if (is_ws(char_in))
            begin
                if (in_arg_reg)
                begin
                    n           = 2'd1;
                    kinds[0]    = KIND_ENDARG;
                    in_arg_next = 1'b0;
                end
            end
            else if (char_in == CH_BSLASH)
                esc_next = 1'b1;
            else
            begin
                do_start = 1'b1;
                priority if (char_in == CH_DQUOTE)
                    quote_next = QM_DOUBLE;
                else if (char_in == CH_SQUOTE)
                    quote_next = QM_SINGLE;
                else
                begin
                    n        = 2'd1;
                    chars[0] = char_in;
                end
            end
        end

        if (do_start && !in_arg_reg)
        begin
            in_arg_next = 1'b1;
            total_next  = sat_inc;
        end

        // end of string returns everything to the reset state
        if (is_end)
        begin
            in_arg_next = 1'b0;
            quote_next  = QM_NONE;
            esc_next    = 1'b0;
            total_next  = '0;
        end
    end

    always_comb
    begin
        bundle.n     = n;
        bundle.kind  = kinds;
        bundle.chr   = chars;
        bundle.count = OUT_COUNT_WIDTH'(start_eff ? sat_inc : total_reg);
        bundle_push  = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_arg_reg <= 1'b0;
            quote_reg  <= QM_NONE;
            esc_reg    <= 1'b0;
            total_reg  <= '0;
        end
        else if (accept)
        begin
            in_arg_reg <= in_arg_next;
            quote_reg  <= quote_next;
            esc_reg    <= esc_next;
            total_reg  <= total_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_end |=> total_reg == '0 && !in_arg_reg && !esc_reg)
        else $error("state not cleared after end of string");

    a_end_three_max: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_push && is_end |-> bundle.kind[n - 2'd1] == KIND_ENDSTR)
        else $error("end of string bundle does not close with end marker");

    a_quote_held_esc: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> quote_reg != QM_SINGLE)
        else $error("escape held inside single quotes");

endmodule

@@ sv/sat_queue.sv @@
// ----------------------------------------------------------------------------
// sat_queue
// Short bundle queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module sat_queue
    import sat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    input  logic    rd_en,
    output bundle_t rd_data,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    bundle_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0] rd_ptr_reg, rd_ptr_next;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                     (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign rd_data = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (PTR_W+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (PTR_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_next;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("bundle written into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("bundle read from empty queue");

endmodule

@@ sv/sat_back.sv @@
// ----------------------------------------------------------------------------
// sat_back
// Serializes the head bundle into single results, one per pop.
// ----------------------------------------------------------------------------
module sat_back
    import sat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bundle_t     head,
    input  logic        head_valid,
    input  logic        pop,
    output logic        head_done,
    output logic        empty,
    output logic [1:0]  kind,
    output logic [7:0]  char_out,
    output logic [15:0] arg_count,
    output logic        last
);

    logic [1:0] slot_reg, slot_next;
    logic       take;

    assign empty     = !head_valid;
    assign take      = pop && head_valid;
    assign last      = (slot_reg == head.n - 2'd1);
    assign head_done = take && last;
    assign kind      = head.kind[slot_reg];
    assign char_out  = head.chr[slot_reg];
    assign arg_count = head.count;

    always_comb
    begin
        slot_next = slot_reg;
        if (take)
            slot_next = last ? 2'd0 : slot_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= 2'd0;
        else
            slot_reg <= slot_next;
    end

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> slot_reg < head.n)
        else $error("result slot beyond bundle size");

    a_slot_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> slot_reg == 2'd0)
        else $error("slot left mid-bundle with queue empty");

endmodule
